/* hdl/ppp_pkg.sv */
package ppp_pkg;

    localparam int CW       = 34;
    localparam int CORDIC_N = 24;
    localparam int IW       = $clog2(CORDIC_N);
    localparam int Q_DEPTH  = 2;

    localparam logic signed [CW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [CW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [CW-1:0] INV_GAIN    = 34'sd652032874;
    localparam logic signed [18:0]   PI_Q16      = 19'sd205887;

    localparam logic signed [23:0] DEF_MOUNT_OFS_X = 24'sd0;
    localparam logic signed [23:0] DEF_MOUNT_OFS_Y = 24'sd0;
    localparam logic signed [23:0] DEF_ARM_BASE_Z  = 24'sd0;
    localparam logic signed [23:0] DEF_LIFT_FLOOR_Z = 24'sd0;
    localparam logic signed [23:0] DEF_LIFT_CEIL_Z  = 24'sd32768;

    typedef enum logic [2:0] {
        CFG_PREF_X   = 3'd0,
        CFG_PREF_Y   = 3'd1,
        CFG_PREF_Z   = 3'd2,
        CFG_PITCH    = 3'd3,
        CFG_APPROACH = 3'd4,
        CFG_RAISE    = 3'd5,
        CFG_WITHDRAW = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
        logic signed [18:0] pitch;
        logic signed [23:0] app;
        logic signed [23:0] rai;
        logic signed [23:0] wd;
    } t_cfg;

    typedef struct packed {
        logic               op;
        logic signed [23:0] dx;
        logic signed [23:0] dy;
        logic signed [23:0] lift;
        logic               oor;
    } t_job;

    typedef enum logic [2:0] {
        B_IDLE,
        B_VEC,
        B_ROT,
        B_MUL,
        B_EMIT
    } t_bstate;

    function automatic logic signed [CW-1:0] atan_q30(input logic [IW-1:0] i);
        logic signed [CW-1:0] v;
        case (i)
            5'd0:    v = 34'sh3243F6A8;
            5'd1:    v = 34'sh1DAC6705;
            5'd2:    v = 34'sh0FADBAFC;
            5'd3:    v = 34'sh07F56EA6;
            5'd4:    v = 34'sh03FEAB76;
            5'd5:    v = 34'sh01FFD55B;
            5'd6:    v = 34'sh00FFFAAA;
            5'd7:    v = 34'sh007FFF55;
            5'd8:    v = 34'sh003FFFEA;
            5'd9:    v = 34'sh001FFFFD;
            5'd10:   v = 34'sh000FFFFF;
            5'd11:   v = 34'sh0007FFFF;
            5'd12:   v = 34'sh0003FFFF;
            5'd13:   v = 34'sh0001FFFF;
            5'd14:   v = 34'sh0000FFFF;
            5'd15:   v = 34'sh00007FFF;
            5'd16:   v = 34'sh00003FFF;
            5'd17:   v = 34'sh00001FFF;
            5'd18:   v = 34'sh00000FFF;
            5'd19:   v = 34'sh000007FF;
            5'd20:   v = 34'sh000003FF;
            5'd21:   v = 34'sh000001FF;
            5'd22:   v = 34'sh000000FF;
            5'd23:   v = 34'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
        logic signed [23:0] r;
        if (v > 36'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -36'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] sat_pi(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > Q30_PI) begin
            r = Q30_PI;
        end else if (v < -Q30_PI) begin
            r = -Q30_PI;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'sd536870912;
        return t[65:30];
    endfunction

    function automatic logic signed [29:0] rnd36(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'sd34359738368;
        return t[65:36];
    endfunction

endpackage

/* hdl/ppp_front.sv */
module ppp_front #(
    parameter logic signed [23:0] MOUNT_OFS_X  = ppp_pkg::DEF_MOUNT_OFS_X,
    parameter logic signed [23:0] MOUNT_OFS_Y  = ppp_pkg::DEF_MOUNT_OFS_Y,
    parameter logic signed [23:0] ARM_BASE_Z   = ppp_pkg::DEF_ARM_BASE_Z,
    parameter logic signed [23:0] LIFT_FLOOR_Z = ppp_pkg::DEF_LIFT_FLOOR_Z,
    parameter logic signed [23:0] LIFT_CEIL_Z  = ppp_pkg::DEF_LIFT_CEIL_Z
) (
    input  logic               i_start,
    input  logic               i_full,
    input  logic               i_op,
    input  logic signed [23:0] i_target_x,
    input  logic signed [23:0] i_target_y,
    input  logic signed [23:0] i_target_z,
    input  ppp_pkg::t_cfg      i_cfg,
    output logic               o_push,
    output ppp_pkg::t_job      o_job
);
    import ppp_pkg::*;

    logic signed [35:0] dxw;
    logic signed [35:0] dyw;
    logic signed [35:0] liftw;

    always_comb begin
        dxw   = 36'(i_target_x) - 36'(MOUNT_OFS_X) - 36'(i_cfg.px);
        dyw   = 36'(i_target_y) - 36'(MOUNT_OFS_Y) - 36'(i_cfg.py);
        liftw = 36'(i_target_z) - 36'(ARM_BASE_Z) - 36'(i_cfg.pz);
        o_job.op   = i_op;
        o_job.dx   = sat24(dxw);
        o_job.dy   = sat24(dyw);
        o_job.lift = sat24(liftw);
        o_job.oor  = (liftw < 36'(LIFT_FLOOR_Z)) || (liftw > 36'(LIFT_CEIL_Z));
        o_push     = i_start && !i_full;
    end

endmodule

/* hdl/ppp_queue.sv */
module ppp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ppp_pkg::t_job i_job,
    input  logic          i_pop,
    output ppp_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);
    import ppp_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_job          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    always_comb begin
        o_job   = r_mem[r_rp];
        o_empty = (r_cnt == '0);
        o_full  = (r_cnt == (PW+1)'(Q_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

/* hdl/ppp_cordic.sv */
module ppp_cordic (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_vec,
    input  logic signed [ppp_pkg::CW-1:0]  i_x,
    input  logic signed [ppp_pkg::CW-1:0]  i_y,
    input  logic signed [ppp_pkg::CW-1:0]  i_z,
    output logic signed [ppp_pkg::CW-1:0]  o_x,
    output logic signed [ppp_pkg::CW-1:0]  o_y,
    output logic signed [ppp_pkg::CW-1:0]  o_z,
    output logic                           o_done
);
    import ppp_pkg::*;

    logic signed [CW-1:0] r_x, r_y, r_z;
    logic signed [CW-1:0] n_x, n_y, n_z;
    logic signed [CW-1:0] x0, y0, z0;
    logic signed [CW-1:0] xs, ys, t;
    logic                 neg0;
    logic                 d;
    logic [IW-1:0]        r_i;
    logic                 r_run, r_vec, r_neg, r_done;

    always_comb begin
        neg0 = 1'b0;
        x0   = i_x;
        y0   = i_y;
        z0   = '0;
        if (i_vec) begin
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    x0 = i_y;
                    y0 = -i_x;
                    z0 = Q30_HALF_PI;
                end else begin
                    x0 = -i_y;
                    y0 = i_x;
                    z0 = -Q30_HALF_PI;
                end
            end
        end else begin
            x0 = INV_GAIN;
            y0 = '0;
            z0 = i_z;
            if (i_z > Q30_HALF_PI) begin
                z0   = i_z - Q30_PI;
                neg0 = 1'b1;
            end else if (i_z < -Q30_HALF_PI) begin
                z0   = i_z + Q30_PI;
                neg0 = 1'b1;
            end
        end

        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        t  = atan_q30(r_i);
        d  = r_vec ? (r_y > 0) : (r_z < 0);
        if (d) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + t;
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - t;
        end

        o_x    = r_neg ? -r_x : r_x;
        o_y    = r_neg ? -r_y : r_y;
        o_z    = r_z;
        o_done = r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_i == IW'(CORDIC_N - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= x0;
            r_y   <= y0;
            r_z   <= z0;
            r_i   <= '0;
            r_vec <= i_vec;
            r_neg <= neg0;
        end else if (r_run) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_i <= r_i + 1'b1;
        end
    end

endmodule

/* hdl/ppp_back.sv */
module ppp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppp_pkg::t_cfg      i_cfg,
    input  logic               i_empty,
    input  ppp_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_valid,
    output logic               o_status,
    output logic signed [23:0] o_delta_x,
    output logic signed [23:0] o_delta_y,
    output logic signed [18:0] o_heading,
    output logic [22:0]        o_distance,
    output logic signed [23:0] o_lift_z,
    output logic [1:0]         o_pose_step,
    output logic signed [23:0] o_pose_x,
    output logic signed [23:0] o_pose_y,
    output logic signed [23:0] o_pose_z,
    output logic               o_last
);
    import ppp_pkg::*;

    t_bstate              r_state, n_state;
    logic [3:0]           r_k, n_k;
    t_job                 r_job;
    logic signed [CW-1:0] r_vx, r_cp, r_ax, r_ay, r_az;
    logic signed [31:0]   r_cy, r_syw;
    logic signed [18:0]   r_head;
    logic [29:0]          r_mag;
    logic signed [65:0]   r_prod;
    logic signed [27:0]   r_tax, r_tay, r_taz, r_twx, r_twy, r_twz;

    logic                 a_start, b_start, c_vec;
    logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
    logic signed [CW-1:0] ao_x, ao_y, ao_z, bo_x, bo_y, bo_z;
    logic                 a_done, b_done;
    logic signed [CW-1:0] yaw, ang;
    logic signed [34:0]   hrnd;
    logic signed [20:0]   hq;
    logic signed [18:0]   head;
    logic signed [CW-1:0] ma;
    logic signed [31:0]   mb;
    logic signed [65:0]   prod;
    logic signed [35:0]   rv;
    logic signed [29:0]   dxa;
    logic [1:0]           sel;
    logic signed [27:0]   px, py, pz, rai, qx, qy, qz;
    logic                 fin;

    logic                 r_valid, r_status, r_last;
    logic signed [23:0]   r_dx, r_dy, r_lift, r_pxo, r_pyo, r_pzo;
    logic signed [18:0]   r_hd;
    logic [22:0]          r_dist;
    logic [1:0]           r_step;

    ppp_cordic u_cordic_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (a_start),
        .i_vec   (c_vec),
        .i_x     (a_x),
        .i_y     (a_y),
        .i_z     (a_z),
        .o_x     (ao_x),
        .o_y     (ao_y),
        .o_z     (ao_z),
        .o_done  (a_done)
    );

    ppp_cordic u_cordic_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (b_start),
        .i_vec   (c_vec),
        .i_x     (b_x),
        .i_y     (b_y),
        .i_z     (b_z),
        .o_x     (bo_x),
        .o_y     (bo_y),
        .o_z     (bo_z),
        .o_done  (b_done)
    );

    always_comb begin
        c_vec   = (r_state == B_IDLE);
        o_pop   = (r_state == B_IDLE) && !i_empty;
        a_start = o_pop || ((r_state == B_VEC) && a_done);
        b_start = a_start;

        if (i_cfg.py == '0) begin
            yaw = (i_cfg.px < 0) ? Q30_PI : '0;
        end else begin
            yaw = sat_pi(bo_z);
        end
        if (r_job.dy == '0) begin
            ang = (r_job.dx < 0) ? Q30_PI : '0;
        end else begin
            ang = sat_pi(ao_z);
        end
        hrnd = 35'(ang) + 35'sd8192;
        hq   = hrnd[34:14];
        if (hq > 21'(PI_Q16)) begin
            head = PI_Q16;
        end else if (hq < -21'(PI_Q16)) begin
            head = -PI_Q16;
        end else begin
            head = hq[18:0];
        end

        a_x = CW'(i_job.dx) <<< 6;
        a_y = CW'(i_job.dy) <<< 6;
        a_z = yaw;
        b_x = CW'(i_cfg.px) <<< 6;
        b_y = CW'(i_cfg.py) <<< 6;
        b_z = CW'(i_cfg.pitch) <<< 14;

        case (r_k)
            4'd0: begin ma = r_vx; mb = INV_GAIN[31:0]; end
            4'd1: begin ma = r_cp; mb = r_cy; end
            4'd2: begin ma = r_cp; mb = r_syw; end
            4'd3: begin ma = r_ax; mb = 32'(i_cfg.app); end
            4'd4: begin ma = r_ay; mb = 32'(i_cfg.app); end
            4'd5: begin ma = r_az; mb = 32'(i_cfg.app); end
            4'd6: begin ma = r_ax; mb = 32'(i_cfg.wd); end
            4'd7: begin ma = r_ay; mb = 32'(i_cfg.wd); end
            4'd8: begin ma = r_az; mb = 32'(i_cfg.wd); end
            default: begin ma = '0; mb = '0; end
        endcase
        prod = ma * mb;
        rv   = rnd30(r_prod);
        dxa  = 30'(r_job.dx);
        if (dxa < 0) begin
            dxa = -dxa;
        end

        if (r_job.op) begin
            case (r_k[1:0])
                2'd0:    sel = 2'd3;
                2'd1:    sel = 2'd2;
                2'd2:    sel = 2'd1;
                default: sel = 2'd3;
            endcase
        end else begin
            sel = r_k[1:0];
        end
        px  = 28'(i_cfg.px);
        py  = 28'(i_cfg.py);
        pz  = 28'(i_cfg.pz);
        rai = 28'(i_cfg.rai);
        case (sel)
            2'd0: begin qx = px - r_tax; qy = py - r_tay; qz = pz - r_taz; end
            2'd1: begin qx = px; qy = py; qz = pz; end
            2'd2: begin qx = px; qy = py; qz = pz + rai; end
            default: begin qx = px - r_twx; qy = py - r_twy; qz = pz + rai - r_twz; end
        endcase
        fin = r_job.oor || (r_k[1:0] == 2'd3);

        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = B_VEC;
                end
            end
            B_VEC: begin
                if (a_done) begin
                    n_state = B_ROT;
                end
            end
            B_ROT: begin
                if (a_done) begin
                    n_state = B_MUL;
                    n_k     = '0;
                end
            end
            B_MUL: begin
                if (r_k == 4'd9) begin
                    n_state = B_EMIT;
                    n_k     = '0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            B_EMIT: begin
                if (fin) begin
                    n_state = B_IDLE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_valid <= (r_state == B_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == B_VEC && a_done) begin
            r_vx   <= ao_x;
            r_head <= head;
        end
        if (r_state == B_ROT && a_done) begin
            r_cy  <= ao_x[31:0];
            r_syw <= ao_y[31:0];
            r_cp  <= bo_x;
            r_az  <= -bo_y;
        end
        if (r_state == B_MUL) begin
            r_prod <= prod;
            case (r_k)
                4'd1: r_mag <= (r_job.dy == '0) ? 30'(dxa) : 30'(rnd36(r_prod));
                4'd2: r_ax  <= rv[CW-1:0];
                4'd3: r_ay  <= rv[CW-1:0];
                4'd4: r_tax <= rv[27:0];
                4'd5: r_tay <= rv[27:0];
                4'd6: r_taz <= rv[27:0];
                4'd7: r_twx <= rv[27:0];
                4'd8: r_twy <= rv[27:0];
                4'd9: r_twz <= rv[27:0];
                default: ;
            endcase
        end
        if (r_state == B_EMIT) begin
            r_status <= r_job.oor;
            r_last   <= fin;
            r_step   <= r_job.oor ? 2'd0 : r_k[1:0];
            if (r_job.oor && r_job.op) begin
                r_dx   <= '0;
                r_dy   <= '0;
                r_hd   <= '0;
                r_dist <= '0;
                r_lift <= '0;
            end else begin
                r_dx   <= r_job.dx;
                r_dy   <= r_job.dy;
                r_hd   <= r_head;
                r_dist <= (r_mag > 30'd8388607) ? 23'h7FFFFF : r_mag[22:0];
                r_lift <= r_job.lift;
            end
            if (r_job.oor) begin
                r_pxo <= '0;
                r_pyo <= '0;
                r_pzo <= '0;
            end else begin
                r_pxo <= sat24(36'(qx));
                r_pyo <= sat24(36'(qy));
                r_pzo <= sat24(36'(qz));
            end
        end
    end

    always_comb begin
        o_valid     = r_valid;
        o_status    = r_status;
        o_delta_x   = r_dx;
        o_delta_y   = r_dy;
        o_heading   = r_hd;
        o_distance  = r_dist;
        o_lift_z    = r_lift;
        o_pose_step = r_step;
        o_pose_x    = r_pxo;
        o_pose_y    = r_pyo;
        o_pose_z    = r_pzo;
        o_last      = r_last;
    end

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_last |=> !r_valid)
        else $error("result right after last");

    a_step_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_last |=> r_valid && (r_step == $past(r_step) + 2'd1))
        else $error("pose step did not advance");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status |-> r_last && (r_step == 2'd0))
        else $error("error result not single");

    a_cordic_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_done == b_done)
        else $error("cordic units out of step");

endmodule

/* hdl/pick_place_pose_planner.sv */
// channel   | signals                                   | direction | handshake
// ----------+-------------------------------------------+-----------+------------------------
// request   | i_op, i_target_x/y/z                      | in        | start && !busy
// config    | i_cfg_we, i_cfg_addr, i_cfg_wdata         | in        | i_cfg_we, no wait
// result    | o_status ... o_pose_z, o_pose_step, o_last| out       | o_valid, one cycle each
//
// An item goes from the queue into the planner, then through two CORDIC passes of 24 steps
// back to back (vector, then rotate) and a ten-step shared multiplier sequence, and ends in
// four results (one result when the lift is out of range). The planner takes the next item
// from the queue only after the last result of the current one. Two items queue ahead of it;
// busy is high while the queue is full. Reset is synchronous, active low, and empties the
// queue and the planner.
// Results cannot be held off by the receiver.
module pick_place_pose_planner #(
    parameter logic signed [23:0] MOUNT_OFS_X  = ppp_pkg::DEF_MOUNT_OFS_X,
    parameter logic signed [23:0] MOUNT_OFS_Y  = ppp_pkg::DEF_MOUNT_OFS_Y,
    parameter logic signed [23:0] ARM_BASE_Z   = ppp_pkg::DEF_ARM_BASE_Z,
    parameter logic signed [23:0] LIFT_FLOOR_Z = ppp_pkg::DEF_LIFT_FLOOR_Z,
    parameter logic signed [23:0] LIFT_CEIL_Z  = ppp_pkg::DEF_LIFT_CEIL_Z
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic signed [23:0] i_target_x,
    input  logic signed [23:0] i_target_y,
    input  logic signed [23:0] i_target_z,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [23:0]        i_cfg_wdata,
    output logic               o_valid,
    output logic               o_status,
    output logic signed [23:0] o_delta_x,
    output logic signed [23:0] o_delta_y,
    output logic signed [18:0] o_heading,
    output logic [22:0]        o_distance,
    output logic signed [23:0] o_lift_z,
    output logic [1:0]         o_pose_step,
    output logic signed [23:0] o_pose_x,
    output logic signed [23:0] o_pose_y,
    output logic signed [23:0] o_pose_z,
    output logic               o_last
);
    import ppp_pkg::*;

    t_cfg r_cfg;
    t_job f_job, q_job;
    logic push, pop, q_empty, q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_PREF_X:   r_cfg.px    <= i_cfg_wdata;
                CFG_PREF_Y:   r_cfg.py    <= i_cfg_wdata;
                CFG_PREF_Z:   r_cfg.pz    <= i_cfg_wdata;
                CFG_PITCH:    r_cfg.pitch <= i_cfg_wdata[18:0];
                CFG_APPROACH: r_cfg.app   <= i_cfg_wdata;
                CFG_RAISE:    r_cfg.rai   <= i_cfg_wdata;
                CFG_WITHDRAW: r_cfg.wd    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign busy = q_full;

    ppp_front #(
        .MOUNT_OFS_X  (MOUNT_OFS_X),
        .MOUNT_OFS_Y  (MOUNT_OFS_Y),
        .ARM_BASE_Z   (ARM_BASE_Z),
        .LIFT_FLOOR_Z (LIFT_FLOOR_Z),
        .LIFT_CEIL_Z  (LIFT_CEIL_Z)
    ) u_front (
        .i_start    (start),
        .i_full     (q_full),
        .i_op       (i_op),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .i_target_z (i_target_z),
        .i_cfg      (r_cfg),
        .o_push     (push),
        .o_job      (f_job)
    );

    ppp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ppp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (q_empty),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_delta_x   (o_delta_x),
        .o_delta_y   (o_delta_y),
        .o_heading   (o_heading),
        .o_distance  (o_distance),
        .o_lift_z    (o_lift_z),
        .o_pose_step (o_pose_step),
        .o_pose_x    (o_pose_x),
        .o_pose_y    (o_pose_y),
        .o_pose_z    (o_pose_z),
        .o_last      (o_last)
    );

endmodule
